[rtl/fdr_pkg.sv]
`timescale 1ns / 1ps
// fdr_pkg: widths shared by the Fresnel reflectance unit and its interfaces.
// No dependencies.
package fdr_pkg;

  localparam int unsigned CI_W     = 16;  // cos_incident, signed Q1.14
  localparam int unsigned IOR_W    = 16;  // ior_ratio, unsigned Q4.12
  localparam int unsigned REFL_W   = 16;  // reflectance
  localparam int unsigned N2_W     = 36;  // n^2 in Q28
  localparam int unsigned U_W      = 37;  // n^2 - sin^2(theta_i), Q28
  localparam int unsigned CT2_FRAC = 32;  // cos_t^2 fraction bits
  localparam int unsigned CT2_W    = 59;  // cos_t^2 in Q32
  localparam int unsigned CT_W     = 30;  // cos_t in Q16
  localparam int unsigned RAT_W    = 48;  // ratio numerator/denominator
  localparam int unsigned RQ_FRAC  = 30;  // ratio fraction bits
  localparam int unsigned RQ_W     = 31;  // unsaturated ratio quotient
  localparam int unsigned RP_W     = 32;  // ratio incl. saturation value

endpackage

[rtl/fdr_if.sv]
`timescale 1ns / 1ps
// fdr_in_if / fdr_out_if: valid/ready channels of the Fresnel unit.
// Depends on fdr_pkg.
interface fdr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [fdr_pkg::CI_W-1:0]   cos_incident;
  logic        [fdr_pkg::IOR_W-1:0]  ior_ratio;

  modport source(output valid, cos_incident, ior_ratio, input ready);
  modport sink(input valid, cos_incident, ior_ratio, output ready);
endinterface

interface fdr_out_if;
  logic                              valid;
  logic                              ready;
  logic [fdr_pkg::REFL_W-1:0]        reflectance;
  logic                              total_internal_reflection;

  modport source(output valid, reflectance, total_internal_reflection, input ready);
  modport sink(input valid, reflectance, total_internal_reflection, output ready);
endinterface

[rtl/fresnel_dielectric_reflectance_unit.sv]
`timescale 1ns / 1ps
// Unpolarized dielectric Fresnel reflectance, fully pipelined.
// Order: setup, the cos_t^2 divider, the square root, products, ratio terms and
// saturation, the two parallel ratio dividers, then squares, halved sum and rounding.
// Throughput one item per cycle; the whole pipe holds while the output stalls.
// Reset clears all valid bits asynchronously; data registers are not reset.
// Depends on fdr_pkg, fdr_if, fdr_div_pipe, fdr_sqrt_pipe.
module fresnel_dielectric_reflectance_unit #(
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fdr_in_if.sink    in_i,
  fdr_out_if.source out_o
);

  import fdr_pkg::*;

  typedef logic signed [N2_W+1:0]  cmp_t;
  typedef logic signed [RAT_W-1:0] rat_t;

  localparam logic signed [32:0] ONE_Q28 = 33'sh1000_0000;
  localparam logic [63:0] ONE_OUT = 64'd1 << OUT_FRAC_BITS;
  localparam logic [63:0] RND     = 64'd1 << (59 - OUT_FRAC_BITS);
  localparam int unsigned SHR     = 60 - OUT_FRAC_BITS;
  localparam int unsigned SIDE1_W = 1 + CI_W + IOR_W;

  function automatic logic [RAT_W-1:0] mag(input rat_t x);
    return x[RAT_W-1] ? RAT_W'(-x) : RAT_W'(x);
  endfunction

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---- stage A: sin^2 test and u = n^2 - sin^2(theta_i)
  logic signed [CI_W-1:0]   c_in;
  logic        [IOR_W-1:0]  n_in;
  logic signed [2*CI_W-1:0] c_sq;
  logic        [2*IOR_W-1:0] n_sq;
  logic signed [32:0]       s2i;
  cmp_t                     s2i_x, n2_x;
  logic                     tir_d;

  assign c_in  = in_i.cos_incident;
  assign n_in  = in_i.ior_ratio;
  assign c_sq  = (2*CI_W)'(c_in) * (2*CI_W)'(c_in);
  assign n_sq  = (2*IOR_W)'(n_in) * (2*IOR_W)'(n_in);
  assign s2i   = ONE_Q28 - 33'(c_sq);
  assign s2i_x = cmp_t'(s2i);
  assign n2_x  = cmp_t'({n_sq, 4'b0000});
  assign tir_d = (n_in == '0) || (s2i_x >= n2_x);

  logic                    a_vld_q, a_tir_q;
  logic [U_W-1:0]          a_u_q;
  logic [N2_W-1:0]         a_n2_q;
  logic signed [CI_W-1:0]  a_c_q;
  logic [IOR_W-1:0]        a_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_tir_q <= tir_d;
      a_u_q   <= U_W'(n2_x - s2i_x);
      a_n2_q  <= {n_sq, 4'b0000};
      a_c_q   <= c_in;
      a_n_q   <= n_in;
    end
  end

  // ---- cos_t^2 = u / n^2 in Q32
  logic               d1_vld;
  logic [CT2_W-1:0]   d1_quo;
  logic [SIDE1_W-1:0] d1_side;

  fdr_div_pipe #(
    .NUM_W (U_W + CT2_FRAC),
    .DEN_W (N2_W),
    .Q_W   (CT2_W),
    .SIDE_W(SIDE1_W)
  ) u_ct2_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(a_vld_q),
    .num_i  ({a_u_q, {CT2_FRAC{1'b0}}}),
    .den_i  (a_n2_q),
    .side_i ({a_tir_q, a_c_q, a_n_q}),
    .valid_o(d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side)
  );

  // ---- cos_t in Q16
  logic               sq_vld;
  logic [CT_W-1:0]    sq_root;
  logic [SIDE1_W-1:0] sq_side;

  fdr_sqrt_pipe #(
    .R_W   (CT_W),
    .SIDE_W(SIDE1_W)
  ) u_ct_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(d1_vld),
    .rad_i  ({{(2*CT_W-CT2_W){1'b0}}, d1_quo}),
    .side_i (d1_side),
    .valid_o(sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // ---- stage B: products n*c and n*cos_t
  logic                    sq_tir;
  logic signed [CI_W-1:0]  sq_c;
  logic [IOR_W-1:0]        sq_n;
  logic signed [IOR_W:0]   sq_n_s;

  assign {sq_tir, sq_c, sq_n} = sq_side;
  assign sq_n_s = {1'b0, sq_n};

  logic                          b_vld_q, b_tir_q;
  logic signed [CI_W+IOR_W:0]    b_a_q;
  logic [IOR_W+CT_W-1:0]         b_e_q;
  logic [CT_W-1:0]               b_ct_q;
  logic signed [CI_W-1:0]        b_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_tir_q <= sq_tir;
      b_a_q   <= (CI_W+IOR_W+1)'(sq_c) * (CI_W+IOR_W+1)'(sq_n_s);
      b_e_q   <= (IOR_W+CT_W)'(sq_n) * (IOR_W+CT_W)'(sq_root);
      b_ct_q  <= sq_root;
      b_c_q   <= sq_c;
    end
  end

  // ---- stage C: ratio numerators and denominators
  rat_t a_x, b_x, c28_x, e_x;

  assign a_x   = rat_t'(b_a_q);
  assign b_x   = rat_t'({b_ct_q, 10'b0});
  assign c28_x = rat_t'(b_c_q) <<< 14;
  assign e_x   = rat_t'(b_e_q);

  logic c_vld_q, c_tir_q;
  rat_t c_pn_q, c_pd_q, c_sn_q, c_sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_tir_q <= b_tir_q;
      c_pn_q  <= a_x - b_x;
      c_pd_q  <= a_x + b_x;
      c_sn_q  <= c28_x - e_x;
      c_sd_q  <= c28_x + e_x;
    end
  end

  // ---- stage D: magnitudes and saturation (zero denominator or ratio >= 2)
  logic [RAT_W-1:0] pn_m, pd_m, sn_m, sd_m;

  assign pn_m = mag(c_pn_q);
  assign pd_m = mag(c_pd_q);
  assign sn_m = mag(c_sn_q);
  assign sd_m = mag(c_sd_q);

  logic             d_vld_q, d_tir_q, d_psat_q, d_ssat_q;
  logic [RAT_W-1:0] d_pn_q, d_pd_q, d_sn_q, d_sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_tir_q  <= c_tir_q;
      d_psat_q <= (pd_m == '0) || ({1'b0, pn_m} >= {pd_m, 1'b0});
      d_ssat_q <= (sd_m == '0) || ({1'b0, sn_m} >= {sd_m, 1'b0});
      d_pn_q   <= pn_m;
      d_pd_q   <= pd_m;
      d_sn_q   <= sn_m;
      d_sd_q   <= sd_m;
    end
  end

  // ---- ratio dividers, Q30
  logic            rp_vld;
  logic [RQ_W-1:0] rp_quo, rs_quo;
  logic [1:0]      rp_side;
  logic            rs_side;
  logic            rs_vld;

  fdr_div_pipe #(
    .NUM_W (RAT_W + RQ_FRAC),
    .DEN_W (RAT_W),
    .Q_W   (RQ_W),
    .SIDE_W(2)
  ) u_parl_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(d_vld_q),
    .num_i  ({d_pn_q, {RQ_FRAC{1'b0}}}),
    .den_i  (d_pd_q),
    .side_i ({d_tir_q, d_psat_q}),
    .valid_o(rp_vld),
    .quo_o  (rp_quo),
    .side_o (rp_side)
  );

  fdr_div_pipe #(
    .NUM_W (RAT_W + RQ_FRAC),
    .DEN_W (RAT_W),
    .Q_W   (RQ_W),
    .SIDE_W(1)
  ) u_perp_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(d_vld_q),
    .num_i  ({d_sn_q, {RQ_FRAC{1'b0}}}),
    .den_i  (d_sd_q),
    .side_i (d_ssat_q),
    .valid_o(rs_vld),
    .quo_o  (rs_quo),
    .side_o (rs_side)
  );

  // ---- stage F: squares of the saturated ratios
  logic [RP_W-1:0] rp, rs;

  assign rp = rp_side[0] ? {1'b1, {(RP_W-1){1'b0}}} : {1'b0, rp_quo};
  assign rs = rs_side    ? {1'b1, {(RP_W-1){1'b0}}} : {1'b0, rs_quo};

  logic            f_vld_q, f_tir_q;
  logic [2*RP_W-1:0] f_sp_q, f_ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= rp_vld & rs_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_tir_q <= rp_side[1];
      f_sp_q  <= (2*RP_W)'(rp) * (2*RP_W)'(rp);
      f_ss_q  <= (2*RP_W)'(rs) * (2*RP_W)'(rs);
    end
  end

  // ---- stage G: halved sum, Q60
  logic              g_vld_q, g_tir_q;
  logic [2*RP_W-2:0] g_sum_q;
  logic [2*RP_W-1:0] f_sum;

  assign f_sum = f_sp_q + f_ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_tir_q <= f_tir_q;
      g_sum_q <= f_sum[2*RP_W-1:1];
    end
  end

  // ---- output register: round half up, saturate to 1.0
  logic [63:0] rounded, res;
  logic [REFL_W-1:0] refl_d;
  logic [REFL_W-1:0] out_refl_q;
  logic              out_tir_q;

  assign rounded = (64'(g_sum_q) + RND) >> SHR;
  assign res     = (rounded > ONE_OUT) ? ONE_OUT : rounded;
  assign refl_d  = g_tir_q ? ONE_OUT[REFL_W-1:0] : res[REFL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_refl_q <= refl_d;
      out_tir_q  <= g_tir_q;
    end
  end

  assign out_o.valid                     = out_vld_q;
  assign out_o.reflectance               = out_refl_q;
  assign out_o.total_internal_reflection = out_tir_q;

endmodule

[rtl/fdr_div_pipe.sv]
`timescale 1ns / 1ps
// fdr_div_pipe: pipelined restoring divider, one quotient bit per stage.
// Standalone; requires num_i < den_i * 2^Q_W.
module fdr_div_pipe #(
  parameter int unsigned NUM_W  = 69,
  parameter int unsigned DEN_W  = 36,
  parameter int unsigned Q_W    = 59,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [Q_W];
  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    low_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    low_in;
    logic [Q_W-1:0]    quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = DEN_W'(num_i >> Q_W);
      assign den_in  = den_i;
      assign low_in  = num_i[Q_W-1:0];
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign shifted = {rem_in, low_in[Q_W-1]};
    assign take    = shifted >= {1'b0, den_in};
    assign diff    = shifted - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        den_q[k]  <= den_in;
        low_q[k]  <= low_in << 1;
        quo_q[k]  <= {quo_in[Q_W-2:0], take};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

[rtl/fdr_sqrt_pipe.sv]
`timescale 1ns / 1ps
// fdr_sqrt_pipe: pipelined floor square root, one root bit per stage.
// Standalone; radicand is 2*R_W bits wide.
module fdr_sqrt_pipe #(
  parameter int unsigned R_W    = 30,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*R_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [R_W-1:0]    root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned V_W = 2 * R_W;

  logic              vld_q  [R_W];
  logic [R_W+1:0]    rem_q  [R_W];
  logic [R_W-1:0]    root_q [R_W];
  logic [V_W-1:0]    low_q  [R_W];
  logic [SIDE_W-1:0] side_q [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic              vld_in;
    logic [R_W+1:0]    rem_in;
    logic [R_W-1:0]    root_in;
    logic [V_W-1:0]    low_in;
    logic [SIDE_W-1:0] side_in;
    logic [R_W+3:0]    shifted;
    logic [R_W+3:0]    trial;
    logic [R_W+3:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign low_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign low_in  = low_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign shifted = {rem_in, low_in[V_W-1:V_W-2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign take    = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    // remainder never exceeds 2*root, so it fits R_W+2 bits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[R_W+1:0] : shifted[R_W+1:0];
        root_q[k] <= {root_in[R_W-2:0], take};
        low_q[k]  <= low_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[R_W-1];
  assign root_o  = root_q[R_W-1];
  assign side_o  = side_q[R_W-1];

endmodule
